// ----- sv/psws_pkg.sv -----
`timescale 1ns / 1ps

package psws_pkg;

    localparam int DEF_BOARDS   = 8;
    localparam int DEF_CHANNELS = 8;
    localparam int DEF_SAMPLES  = 256;
    localparam int CHIP_COUNT   = 4;

    localparam logic [15:0] HITBUS_RESET = 16'h1000;
    localparam logic signed [12:0] STAT_START_MAX = -13'sd4095;
    localparam logic signed [12:0] STAT_START_MIN = 13'sd4095;
    localparam logic [8:0] COUNT_CAP = 9'd256;

    localparam int MUL_STEPS  = 20;
    localparam int ROOT_STEPS = 29;
    localparam int QUO_BITS   = 29;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_SUB  = 2'd1,
        CMD_ADD  = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    typedef struct packed {
        logic signed [20:0] sum;
        logic [32:0]        sum_sq;
        logic [8:0]         count;
    } stat_sums_t;

    typedef struct packed {
        logic signed [20:0] mean;
        logic [19:0]        rms;
    } stat_res_t;

endpackage

// ----- sv/psws_ped_mem.sv -----
`timescale 1ns / 1ps

module psws_ped_mem
    import psws_pkg::*;
#(
    parameter int DEPTH = DEF_BOARDS * CHIP_COUNT * DEF_CHANNELS * DEF_SAMPLES,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [11:0]   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [11:0]   rdata
);

    logic [11:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- sv/psws_finish.sv -----
`timescale 1ns / 1ps

module psws_finish
    import psws_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  stat_sums_t sums,
    output logic       done,
    output stat_res_t  res
);

    typedef enum logic [6:0] {
        F_IDLE = 7'b0000001,
        F_MUL  = 7'b0000010,
        F_DIFF = 7'b0000100,
        F_SQRT = 7'b0001000,
        F_DIVR = 7'b0010000,
        F_DIVM = 7'b0100000,
        F_DONE = 7'b1000000
    } fstate_t;

    fstate_t state_reg, state_next;

    logic [4:0]  cnt_reg;
    logic        neg_reg;
    logic [19:0] sabs_reg;
    logic [8:0]  n_reg;
    logic [40:0] mul_a_reg;
    logic [8:0]  mul_n_reg;
    logic [39:0] mcand_reg;
    logic [19:0] mul_s_reg;
    logic [40:0] acc_a_reg;
    logic [39:0] acc_b_reg;
    logic [57:0] rad_reg;
    logic [28:0] root_reg;
    logic [30:0] rem_reg;
    logic [28:0] dvd_reg;
    logic [8:0]  drem_reg;
    stat_res_t   res_reg;

    logic [19:0] start_abs;
    logic [31:0] rem_sh;
    logic [31:0] trial;
    logic        root_bit;
    logic [28:0] root_nx;
    logic [30:0] rem_nx;
    logic [9:0]  drem_sh;
    logic        q_bit;
    logic [28:0] q_nx;
    logic [8:0]  drem_nx;

    assign start_abs = sums.sum[20] ? 20'(-sums.sum) : 20'(sums.sum);

    always_comb
    begin
        rem_sh   = {rem_reg[29:0], rad_reg[57:56]};
        trial    = {1'b0, root_reg, 2'b01};
        root_bit = rem_sh >= trial;
        root_nx  = {root_reg[27:0], root_bit};
        rem_nx   = root_bit ? 31'(rem_sh - trial) : 31'(rem_sh);
        drem_sh  = {drem_reg, dvd_reg[28]};
        q_bit    = drem_sh >= {1'b0, n_reg};
        q_nx     = {dvd_reg[27:0], q_bit};
        drem_nx  = q_bit ? 9'(drem_sh - {1'b0, n_reg}) : 9'(drem_sh);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    state_next = (sums.count == 9'd0) ? F_DONE : F_MUL;
                end
            end
            F_MUL:
            begin
                if (cnt_reg == 5'(MUL_STEPS - 1))
                begin
                    state_next = F_DIFF;
                end
            end
            F_DIFF:
            begin
                state_next = F_SQRT;
            end
            F_SQRT:
            begin
                if (cnt_reg == 5'(ROOT_STEPS - 1))
                begin
                    state_next = F_DIVR;
                end
            end
            F_DIVR:
            begin
                if (cnt_reg == 5'(QUO_BITS - 1))
                begin
                    state_next = F_DIVM;
                end
            end
            F_DIVM:
            begin
                if (cnt_reg == 5'(QUO_BITS - 1))
                begin
                    state_next = F_DONE;
                end
            end
            F_DONE:
            begin
                state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_next != state_reg)
            begin
                cnt_reg <= 5'd0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    neg_reg   <= sums.sum[20];
                    sabs_reg  <= start_abs;
                    n_reg     <= sums.count;
                    mul_a_reg <= 41'(sums.sum_sq);
                    mul_n_reg <= sums.count;
                    mcand_reg <= 40'(start_abs);
                    mul_s_reg <= start_abs;
                    acc_a_reg <= 41'd0;
                    acc_b_reg <= 40'd0;
                    res_reg   <= '0;
                end
            end
            F_MUL:
            begin
                if (mul_n_reg[0])
                begin
                    acc_a_reg <= acc_a_reg + mul_a_reg;
                end
                if (mul_s_reg[0])
                begin
                    acc_b_reg <= acc_b_reg + mcand_reg;
                end
                mul_a_reg <= {mul_a_reg[39:0], 1'b0};
                mul_n_reg <= {1'b0, mul_n_reg[8:1]};
                mcand_reg <= {mcand_reg[38:0], 1'b0};
                mul_s_reg <= {1'b0, mul_s_reg[19:1]};
            end
            F_DIFF:
            begin
                rad_reg  <= {1'b0, 41'(acc_a_reg - {1'b0, acc_b_reg}), 16'd0};
                root_reg <= 29'd0;
                rem_reg  <= 31'd0;
            end
            F_SQRT:
            begin
                rad_reg  <= {rad_reg[55:0], 2'b00};
                root_reg <= root_nx;
                rem_reg  <= rem_nx;
                if (cnt_reg == 5'(ROOT_STEPS - 1))
                begin
                    dvd_reg  <= root_nx;
                    drem_reg <= 9'd0;
                end
            end
            F_DIVR:
            begin
                dvd_reg  <= q_nx;
                drem_reg <= drem_nx;
                if (cnt_reg == 5'(QUO_BITS - 1))
                begin
                    res_reg.rms <= q_nx[19:0];
                    dvd_reg     <= {1'b0, sabs_reg, 8'd0};
                    drem_reg    <= 9'd0;
                end
            end
            F_DIVM:
            begin
                dvd_reg  <= q_nx;
                drem_reg <= drem_nx;
                if (cnt_reg == 5'(QUO_BITS - 1))
                begin
                    res_reg.mean <= neg_reg ? 21'(-q_nx) : q_nx[20:0];
                end
            end
            F_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign done = (state_reg == F_DONE);
    assign res  = res_reg;

endmodule

// ----- sv/pedestal_subtract_with_stats_unit.sv -----
`timescale 1ns / 1ps
// Pedestal subtraction with per-record statistics. A load beat writes one 12-bit pedestal
// into the on-chip table when its address is in range and gives no result. Subtract and add
// beats read the table through its registered read port, are computed in the execute state
// and move to the output registers once these are free. A subtract beat that closes a
// channel record also runs the shared statistics sequencer: 20 shift-add multiply steps,
// one difference step, 29 square-root steps and two 29-step divisions; with no counted
// samples it skips them. The next beat is accepted while a result waits at the output.

module pedestal_subtract_with_stats_unit
    import psws_pkg::*;
#(
    parameter int BOARDS   = DEF_BOARDS,
    parameter int CHANNELS = DEF_CHANNELS,
    parameter int SAMPLES  = DEF_SAMPLES
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         command,
    input  logic [2:0]         board,
    input  logic [1:0]         chip_id,
    input  logic [2:0]         channel,
    input  logic [7:0]         sample_index,
    input  logic [15:0]        sample_in,
    input  logic               last_sample,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] sample_out,
    output logic               stats_valid,
    output logic signed [12:0] max_value,
    output logic signed [12:0] min_value,
    output logic signed [20:0] mean_q8,
    output logic [19:0]        rms_q8,
    output logic [8:0]         sample_count
);

    localparam int DEPTH = BOARDS * CHIP_COUNT * CHANNELS * SAMPLES;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_FIN  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0]        mask_reg;
    cmd_t               cmd_reg;
    logic [15:0]        word_reg;
    logic               last_reg;
    logic               ok_reg;

    logic signed [12:0] max_reg, max_next;
    logic signed [12:0] min_reg, min_next;
    logic signed [20:0] sum_reg, sum_next;
    logic [32:0]        sq_reg, sq_next;
    logic [8:0]         n_reg, n_next;

    logic signed [15:0] res_sample_reg;
    logic               res_stats_reg;
    logic signed [12:0] res_max_reg;
    logic signed [12:0] res_min_reg;
    logic [8:0]         res_n_reg;

    logic               out_valid_reg;
    logic signed [15:0] out_sample_reg;
    logic               out_stats_reg;
    logic signed [12:0] out_max_reg;
    logic signed [12:0] out_min_reg;
    logic signed [20:0] out_mean_reg;
    logic [19:0]        out_rms_reg;
    logic [8:0]         out_n_reg;

    cmd_t               cmd_in;
    logic               accept;
    logic               addr_ok;
    logic [AW-1:0]      addr;
    logic [11:0]        rdata;
    logic [11:0]        ped;
    logic signed [12:0] diff;
    logic signed [25:0] diff_sq;
    logic               hit;
    logic               upd;
    logic               fin_start;
    logic               fin_done;
    stat_sums_t         fin_sums;
    stat_res_t          fin_res;
    logic               out_load;

    assign cmd_in   = cmd_t'(command);
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    assign addr_ok = (32'(board) < BOARDS) && (32'(channel) < CHANNELS)
                  && (32'(sample_index) < SAMPLES);
    assign addr = AW'(((32'(board) * CHIP_COUNT + 32'(chip_id)) * CHANNELS
                  + 32'(channel)) * SAMPLES + 32'(sample_index));

    psws_ped_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (accept && (cmd_in == CMD_LOAD) && addr_ok),
        .waddr (addr),
        .wdata (sample_in[11:0]),
        .re    (accept),
        .raddr (addr),
        .rdata (rdata)
    );

    assign ped     = ok_reg ? rdata : 12'd0;
    assign diff    = signed'({2'b00, word_reg[10:0]}) - signed'({1'b0, ped});
    assign diff_sq = diff * diff;
    assign hit     = |(word_reg & mask_reg);
    assign upd     = (cmd_reg == CMD_SUB) && !hit && (n_reg < COUNT_CAP);

    always_comb
    begin
        max_next = max_reg;
        min_next = min_reg;
        sum_next = sum_reg;
        sq_next  = sq_reg;
        n_next   = n_reg;
        if (upd)
        begin
            if (diff > max_reg)
            begin
                max_next = diff;
            end
            if (diff < min_reg)
            begin
                min_next = diff;
            end
            sum_next = sum_reg + 21'(diff);
            sq_next  = sq_reg + 33'(unsigned'(diff_sq));
            n_next   = n_reg + 9'd1;
        end
    end

    assign fin_start      = (state_reg == ST_EXEC) && (cmd_reg == CMD_SUB) && last_reg;
    assign fin_sums.sum    = sum_next;
    assign fin_sums.sum_sq = sq_next;
    assign fin_sums.count  = n_next;

    psws_finish u_finish (
        .clk   (clk),
        .rst_n (rst_n),
        .start (fin_start),
        .sums  (fin_sums),
        .done  (fin_done),
        .res   (fin_res)
    );

    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && ((cmd_in == CMD_SUB) || (cmd_in == CMD_ADD)))
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = fin_start ? ST_FIN : ST_OUT;
            end
            ST_FIN:
            begin
                if (fin_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mask_reg      <= HITBUS_RESET;
            max_reg       <= STAT_START_MAX;
            min_reg       <= STAT_START_MIN;
            sum_reg       <= 21'sd0;
            sq_reg        <= 33'd0;
            n_reg         <= 9'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                mask_reg <= cfg_wr_data;
            end
            if (state_reg == ST_EXEC)
            begin
                if (fin_start)
                begin
                    max_reg <= STAT_START_MAX;
                    min_reg <= STAT_START_MIN;
                    sum_reg <= 21'sd0;
                    sq_reg  <= 33'd0;
                    n_reg   <= 9'd0;
                end
                else
                begin
                    max_reg <= max_next;
                    min_reg <= min_next;
                    sum_reg <= sum_next;
                    sq_reg  <= sq_next;
                    n_reg   <= n_next;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= cmd_in;
            word_reg <= sample_in;
            last_reg <= last_sample;
            ok_reg   <= addr_ok;
        end
        if (state_reg == ST_EXEC)
        begin
            if (cmd_reg == CMD_ADD)
            begin
                res_sample_reg <= signed'(word_reg + {4'd0, ped});
            end
            else if (hit)
            begin
                res_sample_reg <= 16'sd0;
            end
            else
            begin
                res_sample_reg <= 16'(diff);
            end
            res_stats_reg <= fin_start;
            res_max_reg   <= max_next;
            res_min_reg   <= min_next;
            res_n_reg     <= n_next;
        end
        if (out_load)
        begin
            out_sample_reg <= res_sample_reg;
            out_stats_reg  <= res_stats_reg;
            out_max_reg    <= res_stats_reg ? res_max_reg : 13'sd0;
            out_min_reg    <= res_stats_reg ? res_min_reg : 13'sd0;
            out_mean_reg   <= res_stats_reg ? fin_res.mean : 21'sd0;
            out_rms_reg    <= res_stats_reg ? fin_res.rms : 20'd0;
            out_n_reg      <= res_stats_reg ? res_n_reg : 9'd0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample_out   = out_sample_reg;
    assign stats_valid  = out_stats_reg;
    assign max_value    = out_max_reg;
    assign min_value    = out_min_reg;
    assign mean_q8      = out_mean_reg;
    assign rms_q8       = out_rms_reg;
    assign sample_count = out_n_reg;

endmodule
